FILE: hdl/dhtr_pkg.sv
// Shared constants for the single-wire humidity/temperature sensor receiver.
// No dependencies; imported by the decoder, the top level and the bench checker.
`default_nettype none

package dhtr_pkg;

  localparam int unsigned COUNTER_WIDTH_DEFAULT = 16;
  localparam int unsigned FRAME_BITS            = 40;

  // configuration register indexes
  localparam logic [1:0] CFG_SENSOR_KIND  = 2'd0;
  localparam logic [1:0] CFG_RESET_LOW    = 2'd1;
  localparam logic [1:0] CFG_EDGE_TIMEOUT = 2'd2;
  localparam logic [1:0] CFG_SAMPLE_DELAY = 2'd3;

  localparam logic        SENSOR_KIND_RST  = 1'b1;
  localparam logic [15:0] RESET_LOW_RST    = 16'd4600;
  localparam logic [7:0]  EDGE_TIMEOUT_RST = 8'd100;
  localparam logic [7:0]  SAMPLE_DELAY_RST = 8'd30;

  // status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_RESP_LOW_TO = 4'd1;
  localparam logic [3:0] ST_RESP_HI_TO  = 4'd2;
  localparam logic [3:0] ST_BIT_FALL_TO = 4'd3;
  localparam logic [3:0] ST_BIT_RISE_TO = 4'd4;
  localparam logic [3:0] ST_NO_STOP     = 4'd5;
  localparam logic [3:0] ST_RELEASE_TO  = 4'd6;
  localparam logic [3:0] ST_TOO_MANY    = 4'd7;
  localparam logic [3:0] ST_CHECKSUM    = 4'd8;

  localparam logic [6:0] SCALE_WHOLE  = 7'd100;
  localparam logic [6:0] SCALE_TENTHS = 7'd10;

  typedef struct packed {
    logic [3:0]         status;
    logic [19:0]        humidity;
    logic signed [19:0] temperature;
  } decode_t;

endpackage

`default_nettype wire

FILE: hdl/dhtr_stream_if.sv
// Valid/ready channel interfaces for line samples in and per-tick results out.
// Depends on nothing beyond plain logic types.
`default_nettype none

interface dhtr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic line_level;

  modport source (output valid, output start_req, output line_level, input ready);
  modport sink   (input valid, input start_req, input line_level, output ready);
endinterface

interface dhtr_out_if;
  logic               valid;
  logic               ready;
  logic               drive_low;
  logic               done_res;
  logic [3:0]         status;
  logic [19:0]        humidity;
  logic signed [19:0] temperature;

  modport source (output valid, output drive_low, output done_res, output status,
                  output humidity, output temperature, input ready);
  modport sink   (input valid, input drive_low, input done_res, input status,
                  input humidity, input temperature, output ready);
endinterface

`default_nettype wire

FILE: hdl/dhtr_decode.sv
// Frame decoder: byte-sum checksum and humidity/temperature scaling.
// Depends on dhtr_pkg.
`default_nettype none

module dhtr_decode (
  input  wire logic [39:0]      frame_i,
  input  wire logic             sensor_kind_i,
  output dhtr_pkg::decode_t     result_o
);
  import dhtr_pkg::*;

  logic [7:0]  b0, b1, b2, b3, b4;
  logic [7:0]  sum8;
  logic [15:0] hum_base, mag_base;
  logic [6:0]  scale;
  logic [22:0] hum_full, mag_full;
  logic [19:0] mag;

  assign b0 = frame_i[39:32];
  assign b1 = frame_i[31:24];
  assign b2 = frame_i[23:16];
  assign b3 = frame_i[15:8];
  assign b4 = frame_i[7:0];

  assign sum8 = b0 + b1 + b2 + b3;

  always_comb begin
    if (sensor_kind_i) begin
      hum_base = {b0, b1};
      mag_base = {1'b0, b2[6:0], b3};
      scale    = SCALE_TENTHS;
    end else begin
      hum_base = {8'd0, b0};
      mag_base = {9'd0, b2[6:0]};
      scale    = SCALE_WHOLE;
    end
  end

  assign hum_full = 23'(hum_base) * 23'(scale);
  assign mag_full = 23'(mag_base) * 23'(scale);
  assign mag      = mag_full[19:0];

  always_comb begin
    if (sum8 != b4) begin
      result_o.status      = ST_CHECKSUM;
      result_o.humidity    = '0;
      result_o.temperature = '0;
    end else begin
      result_o.status      = ST_OK;
      result_o.humidity    = hum_full[19:0];
      // sign flag in bit 7 of the temperature high byte
      result_o.temperature = b2[7] ? $signed(20'd0 - mag) : $signed(mag);
    end
  end

endmodule

`default_nettype wire

FILE: hdl/dht_sensor_receiver.sv
// Top level of the single-wire sensor receiver: sequencer, config registers,
// output register. Depends on dhtr_pkg, dhtr_stream_if and dhtr_decode.
//
// Usage: in_i carries one line sample per transaction (start_req, line_level);
// every accepted sample produces exactly one result transaction on out_o with
// drive_low for the next tick, and done_res/status/humidity/temperature on the
// tick a read ends. A read starts on start_req while idle, drives the line low
// for reset_low_ticks samples, then times the sensor response and 40 data
// bits, checks the stop pulse and the checksum.
// The result of a sample sits in the output register the cycle after it is
// accepted. Throughput is one sample per cycle while out_o is ready; the
// sequencer state and the single output register set that figure, and a new
// sample is taken in the same cycle the previous result is taken.
// When the receiver stalls, the output register holds and in_i.ready drops
// until the result is taken; no sample is lost. Sample timing is in accepted
// transactions, not clock cycles.
// Reset (rst_ni low) returns the sequencer to idle, clears counters and the
// frame, empties the output register and loads the default configuration.
// Configuration writes through cfg_we_i/cfg_idx_i/cfg_data_i take effect at
// once and are meant to be made while no read is in progress.
`default_nettype none

module dht_sensor_receiver #(
  parameter int unsigned COUNTER_WIDTH = dhtr_pkg::COUNTER_WIDTH_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  dhtr_in_if.sink          in_i,
  dhtr_out_if.source       out_o
);
  import dhtr_pkg::*;

  localparam int unsigned EW = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
  localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_REQ_LOW   = 4'd1,
    PH_RESP_FALL = 4'd2,
    PH_RESP_RISE = 4'd3,
    PH_BIT_FALL  = 4'd4,
    PH_BIT_RISE  = 4'd5,
    PH_BIT_WAIT  = 4'd6,
    PH_STOP_FALL = 4'd7,
    PH_STOP_RISE = 4'd8
  } phase_e;

  // configuration
  logic        sensor_kind_q;
  logic [15:0] reset_low_q;
  logic [7:0]  edge_timeout_q;
  logic [7:0]  sample_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_kind_q  <= SENSOR_KIND_RST;
      reset_low_q    <= RESET_LOW_RST;
      edge_timeout_q <= EDGE_TIMEOUT_RST;
      sample_delay_q <= SAMPLE_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SENSOR_KIND:  sensor_kind_q  <= cfg_data_i[0];
        CFG_RESET_LOW:    reset_low_q    <= cfg_data_i;
        CFG_EDGE_TIMEOUT: edge_timeout_q <= cfg_data_i[7:0];
        CFG_SAMPLE_DELAY: sample_delay_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  phase_e                   phase_q, phase_d;
  logic [COUNTER_WIDTH-1:0] tick_q, tick_d;
  logic [5:0]               bit_idx_q, bit_idx_d;
  logic [39:0]              frame_q, frame_d;
  logic                     stop_round_q, stop_round_d;

  // output register
  logic               out_valid_q;
  logic               drive_low_q, drive_low_d;
  logic               done_q, done_d;
  logic [3:0]         status_q, status_d;
  logic [19:0]        hum_q, hum_d;
  logic signed [19:0] temp_q, temp_d;

  logic                     in_acc;
  logic [COUNTER_WIDTH-1:0] tick_inc;
  logic [EW-1:0]            inc_ext;
  logic [15:0]              low_len;
  logic [7:0]               dly;
  logic                     edge_to;
  logic [5:0]               bit_next;
  decode_t                  dec;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign tick_inc = (tick_q == CNT_MAX) ? tick_q : tick_q + COUNTER_WIDTH'(1);
  assign inc_ext  = EW'(tick_inc);
  assign low_len  = (reset_low_q == '0) ? 16'd1 : reset_low_q;
  assign dly      = (sample_delay_q == '0) ? 8'd1 : sample_delay_q;
  assign edge_to  = inc_ext > EW'(edge_timeout_q);
  assign bit_next = bit_idx_q + 6'd1;

  dhtr_decode u_decode (
    .frame_i       (frame_q),
    .sensor_kind_i (sensor_kind_q),
    .result_o      (dec)
  );

  always_comb begin
    phase_d      = phase_q;
    tick_d       = tick_q;
    bit_idx_d    = bit_idx_q;
    frame_d      = frame_q;
    stop_round_d = stop_round_q;
    drive_low_d  = 1'b0;
    done_d       = 1'b0;
    status_d     = ST_OK;
    hum_d        = '0;
    temp_d       = '0;

    unique case (phase_q)
      PH_IDLE: begin
        if (in_i.start_req) begin
          drive_low_d  = 1'b1;
          bit_idx_d    = '0;
          frame_d      = '0;
          stop_round_d = 1'b0;
          if (low_len == 16'd1) begin
            phase_d = PH_RESP_FALL;
            tick_d  = '0;
          end else begin
            phase_d = PH_REQ_LOW;
            tick_d  = COUNTER_WIDTH'(1);
          end
        end
      end
      PH_REQ_LOW: begin
        drive_low_d = 1'b1;
        tick_d      = tick_inc;
        if (inc_ext >= EW'(low_len) || tick_inc == CNT_MAX) begin
          phase_d = PH_RESP_FALL;
          tick_d  = '0;
        end
      end
      PH_RESP_FALL, PH_BIT_FALL: begin
        if (in_i.line_level) begin
          tick_d = tick_inc;
          if (edge_to) begin
            phase_d  = PH_IDLE;
            tick_d   = '0;
            done_d   = 1'b1;
            status_d = (phase_q == PH_RESP_FALL) ? ST_RESP_LOW_TO : ST_BIT_FALL_TO;
          end
        end else begin
          phase_d = (phase_q == PH_RESP_FALL) ? PH_RESP_RISE : PH_BIT_RISE;
          tick_d  = '0;
        end
      end
      PH_RESP_RISE, PH_BIT_RISE: begin
        if (!in_i.line_level) begin
          tick_d = tick_inc;
          if (edge_to) begin
            phase_d  = PH_IDLE;
            tick_d   = '0;
            done_d   = 1'b1;
            status_d = (phase_q == PH_RESP_RISE) ? ST_RESP_HI_TO : ST_BIT_RISE_TO;
          end
        end else begin
          phase_d = (phase_q == PH_RESP_RISE) ? PH_BIT_FALL : PH_BIT_WAIT;
          tick_d  = '0;
        end
      end
      PH_BIT_WAIT: begin
        tick_d = tick_inc;
        if (inc_ext >= EW'(dly) || tick_inc == CNT_MAX) begin
          frame_d   = {frame_q[38:0], in_i.line_level};
          bit_idx_d = bit_next;
          tick_d    = '0;
          if (bit_next >= 6'(FRAME_BITS)) begin
            phase_d      = PH_STOP_FALL;
            stop_round_d = 1'b0;
          end else begin
            phase_d = PH_BIT_FALL;
          end
        end
      end
      PH_STOP_FALL: begin
        if (in_i.line_level) begin
          tick_d = tick_inc;
          if (edge_to) begin
            phase_d = PH_IDLE;
            tick_d  = '0;
            done_d  = 1'b1;
            if (stop_round_q) begin
              status_d = dec.status;
              hum_d    = dec.humidity;
              temp_d   = dec.temperature;
            end else begin
              status_d = ST_NO_STOP;
            end
          end
        end else begin
          // low wait keeps counting from the high wait
          phase_d = PH_STOP_RISE;
        end
      end
      PH_STOP_RISE: begin
        if (!in_i.line_level) begin
          tick_d = tick_inc;
          if (edge_to) begin
            phase_d  = PH_IDLE;
            tick_d   = '0;
            done_d   = 1'b1;
            status_d = ST_RELEASE_TO;
          end
        end else if (!stop_round_q) begin
          stop_round_d = 1'b1;
          phase_d      = PH_STOP_FALL;
          tick_d       = '0;
        end else begin
          phase_d  = PH_IDLE;
          tick_d   = '0;
          done_d   = 1'b1;
          status_d = ST_TOO_MANY;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      tick_q       <= '0;
      bit_idx_q    <= '0;
      frame_q      <= '0;
      stop_round_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q      <= phase_d;
        tick_q       <= tick_d;
        bit_idx_q    <= bit_idx_d;
        frame_q      <= frame_d;
        stop_round_q <= stop_round_d;
        out_valid_q  <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      drive_low_q <= drive_low_d;
      done_q      <= done_d;
      status_q    <= status_d;
      hum_q       <= hum_d;
      temp_q      <= temp_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_low   = drive_low_q;
  assign out_o.done_res    = done_q;
  assign out_o.status      = status_q;
  assign out_o.humidity    = hum_q;
  assign out_o.temperature = temp_q;

  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && phase_q == PH_IDLE && in_i.start_req |=> phase_q != PH_IDLE)
    else $error("start request did not leave idle");

  a_done_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && done_d |=> phase_q == PH_IDLE && tick_q == '0)
    else $error("finished transaction did not return to idle");

  a_quiet_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !done_q |-> status_q == ST_OK && hum_q == '0 && temp_q == '0)
    else $error("result fields set without done");

  a_bit_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_idx_q <= 6'(FRAME_BITS))
    else $error("bit index beyond frame length");

  a_drive_only_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && drive_low_d |=> phase_q == PH_REQ_LOW || phase_q == PH_RESP_FALL)
    else $error("line driven outside request pulse");

endmodule

`default_nettype wire

FILE: tb/dhtr_read_check_pkg.sv
// Tick-accurate prediction and result checking for the sensor receiver bench.
// Depends on dhtr_pkg for status codes, register indexes and reset values.
`timescale 1ns / 1ps

package dhtr_read_check_pkg;
  import dhtr_pkg::*;

  localparam int unsigned TICK_MAX = (1 << COUNTER_WIDTH_DEFAULT) - 1;
  localparam int unsigned REPORT_CAP = 50;

  typedef enum logic [3:0] {
    RX_IDLE, RX_REQ_LOW, RX_RESP_FALL, RX_RESP_RISE, RX_BIT_FALL,
    RX_BIT_RISE, RX_BIT_WAIT, RX_STOP_FALL, RX_STOP_RISE
  } rx_phase_e;

  typedef struct packed {
    logic               drive_low;
    logic               done_res;
    logic [3:0]         status;
    logic [19:0]        humidity;
    logic signed [19:0] temperature;
  } tick_result_t;

  class dht_read_checker;
    logic         sensor_kind;
    logic [15:0]  low_ticks;
    logic [7:0]   edge_limit;
    logic [7:0]   sample_delay;
    rx_phase_e    phase;
    int unsigned  tick_count;
    int unsigned  bits_taken;
    logic [39:0]  frame;
    logic         stop_round;
    tick_result_t cur;
    tick_result_t pending_ticks[$];
    int unsigned  errors;

    function new();
      sensor_kind  = SENSOR_KIND_RST;
      low_ticks    = RESET_LOW_RST;
      edge_limit   = EDGE_TIMEOUT_RST;
      sample_delay = SAMPLE_DELAY_RST;
      phase        = RX_IDLE;
      tick_count   = 0;
      bits_taken   = 0;
      frame        = '0;
      stop_round   = 1'b0;
      errors       = 0;
    endfunction

    function void write_config(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_SENSOR_KIND:  sensor_kind  = val[0];
        CFG_RESET_LOW:    low_ticks    = val;
        CFG_EDGE_TIMEOUT: edge_limit   = val[7:0];
        CFG_SAMPLE_DELAY: sample_delay = val[7:0];
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != RX_IDLE;
    endfunction

    function int unsigned delay_ticks();
      return (sample_delay == 0) ? 1 : sample_delay;
    endfunction

    function int unsigned pending();
      return pending_ticks.size();
    endfunction

    function void bump();
      if (tick_count < TICK_MAX) tick_count++;
    endfunction

    function void end_read(logic [3:0] st);
      phase        = RX_IDLE;
      tick_count   = 0;
      cur.done_res = 1'b1;
      cur.status   = st;
    endfunction

    function void decode_frame();
      logic [7:0]  b0, b1, b2, b3, b4, sum;
      int unsigned hum, mag;
      {b0, b1, b2, b3, b4} = frame;
      sum = b0 + b1 + b2 + b3;
      if (sum != b4) begin
        end_read(ST_CHECKSUM);
        return;
      end
      if (!sensor_kind) begin
        hum = b0 * 100;
        mag = b2[6:0] * 100;
      end else begin
        hum = {b0, b1} * 10;
        mag = {b2[6:0], b3} * 10;
      end
      // sign flag in bit 7 of b2, for either sensor kind: magnitude is negated
      if (b2[7]) mag = 0 - mag;
      end_read(ST_OK);
      cur.humidity    = hum[19:0];
      cur.temperature = mag[19:0];
    endfunction

    function void predict_tick(logic start_req, logic line);
      int unsigned low_len;
      low_len = (low_ticks == 0) ? 1 : low_ticks;
      cur = '0;
      case (phase)
        RX_IDLE: begin
          if (start_req) begin
            cur.drive_low = 1'b1;
            tick_count    = 1;
            bits_taken    = 0;
            frame         = '0;
            stop_round    = 1'b0;
            if (tick_count >= low_len) begin
              phase      = RX_RESP_FALL;
              tick_count = 0;
            end else begin
              phase = RX_REQ_LOW;
            end
          end
        end
        RX_REQ_LOW: begin
          cur.drive_low = 1'b1;
          bump();
          if (tick_count >= low_len || tick_count == TICK_MAX) begin
            phase      = RX_RESP_FALL;
            tick_count = 0;
          end
        end
        RX_RESP_FALL, RX_BIT_FALL: begin
          if (line) begin
            bump();
            if (tick_count > edge_limit)
              end_read((phase == RX_RESP_FALL) ? ST_RESP_LOW_TO : ST_BIT_FALL_TO);
          end else begin
            phase      = (phase == RX_RESP_FALL) ? RX_RESP_RISE : RX_BIT_RISE;
            tick_count = 0;
          end
        end
        RX_RESP_RISE, RX_BIT_RISE: begin
          if (!line) begin
            bump();
            if (tick_count > edge_limit)
              end_read((phase == RX_RESP_RISE) ? ST_RESP_HI_TO : ST_BIT_RISE_TO);
          end else begin
            phase      = (phase == RX_RESP_RISE) ? RX_BIT_FALL : RX_BIT_WAIT;
            tick_count = 0;
          end
        end
        RX_BIT_WAIT: begin
          bump();
          if (tick_count >= delay_ticks() || tick_count == TICK_MAX) begin
            frame      = {frame[38:0], line};
            bits_taken = bits_taken + 1;
            tick_count = 0;
            if (bits_taken >= FRAME_BITS) begin
              phase      = RX_STOP_FALL;
              stop_round = 1'b0;
            end else begin
              phase = RX_BIT_FALL;
            end
          end
        end
        RX_STOP_FALL: begin
          if (line) begin
            bump();
            if (tick_count > edge_limit) begin
              if (stop_round) decode_frame();
              else end_read(ST_NO_STOP);
            end
          end else begin
            // count carries on into the low wait
            phase = RX_STOP_RISE;
          end
        end
        RX_STOP_RISE: begin
          if (!line) begin
            bump();
            if (tick_count > edge_limit) end_read(ST_RELEASE_TO);
          end else if (!stop_round) begin
            stop_round = 1'b1;
            phase      = RX_STOP_FALL;
            tick_count = 0;
          end else begin
            end_read(ST_TOO_MANY);
          end
        end
        default: begin
          phase      = RX_IDLE;
          tick_count = 0;
        end
      endcase
    endfunction

    // accepted sample: predict its result and queue it
    function void note_sample(logic start_req, logic line);
      predict_tick(start_req, line);
      pending_ticks.push_back(cur);
    endfunction

    function void report(string field, longint want, longint got);
      errors++;
      if (errors <= REPORT_CAP)
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
    endfunction

    function void check_tick(logic drive_low, logic done_res, logic [3:0] status,
                             logic [19:0] humidity, logic signed [19:0] temperature);
      tick_result_t want;
      if (pending_ticks.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP) $error("result transaction with no sample pending");
        return;
      end
      want = pending_ticks.pop_front();
      if (drive_low !== want.drive_low) report("drive_low", want.drive_low, drive_low);
      if (done_res !== want.done_res) report("done_res", want.done_res, done_res);
      if (status !== want.status) report("status", want.status, status);
      if (humidity !== want.humidity) report("humidity", want.humidity, humidity);
      if (temperature !== want.temperature)
        report("temperature", want.temperature, temperature);
    endfunction
  endclass

endpackage

FILE: tb/dht_sensor_receiver_test.sv
// Top-level bench for dht_sensor_receiver: emulates the sensor side of the line,
// checks every result tick. Depends on dhtr_pkg, the stream interfaces and dhtr_read_check_pkg.
`timescale 1ns / 1ps

module dht_sensor_receiver_test;
  import dhtr_pkg::*;
  import dhtr_read_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400_000;

  typedef enum int {
    NO_FAULT, RESP_STUCK_HIGH, RESP_STUCK_LOW, BIT_STUCK_HIGH, BIT_STUCK_LOW,
    STOP_MISSING, RELEASE_STUCK, EXTRA_EDGE
  } line_fault_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [15:0] cfg_data;

  dhtr_in_if  in_if();
  dhtr_out_if out_if();

  dht_read_checker sb;
  int unsigned     cycle_count = 0;
  int unsigned     rx_hold_left = 0;
  bit              tx_steady = 1'b0;
  bit              rx_steady = 1'b0;
  bit              pressure_req = 1'b0;
  bit              pressure_done = 1'b0;

  dht_sensor_receiver u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned stall_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin
    logic nxt;
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      nxt = 1'b0;
    end else if (pressure_req && !pressure_done) begin
      pressure_done = 1'b1;
      rx_hold_left  = 299;
      nxt           = 1'b0;
    end else if (rx_steady || $urandom_range(0, 3) != 0) begin
      nxt = 1'b1;
    end else begin
      rx_hold_left = stall_len() - 1;
      nxt          = 1'b0;
    end
    out_if.ready <= nxt;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_tick(out_if.drive_low, out_if.done_res, out_if.status,
                    out_if.humidity, out_if.temperature);
  end

  function automatic logic [39:0] make_frame(logic [7:0] b0, logic [7:0] b1,
                                             logic [7:0] b2, logic [7:0] b3);
    return {b0, b1, b2, b3, 8'(b0 + b1 + b2 + b3)};
  endfunction

  // mostly short edge waits, now and then right at the timeout
  function automatic int pick_wait(int lim);
    if (lim <= 0) return 0;
    if ($urandom_range(0, 7) == 0) return lim;
    return $urandom_range(0, (lim < 3) ? lim : 3);
  endfunction

  // called and returns at a falling edge
  task automatic send_sample(input logic start_req, input logic line);
    int unsigned gap;
    gap = 0;
    if (!tx_steady) begin
      if ($urandom_range(0, 99) >= 70) gap = stall_len();
    end
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.start_req  <= start_req;
    in_if.line_level <= line;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    sb.note_sample(start_req, line);
    @(negedge clk_i);
  endtask

  // line held at one level while a read is in progress; start pulses here are ignored
  task automatic hold_line(input logic lvl, input int n);
    int i;
    for (i = 0; i < n && sb.busy(); i++)
      send_sample($urandom_range(0, 3) == 0, lvl);
  endtask

  task automatic idle_noise(input int n);
    repeat (n) send_sample(1'b0, $urandom_range(0, 1) == 1);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    sb.write_config(idx, val);
    @(negedge clk_i);
  endtask

  task automatic configure(input logic kind, input logic [15:0] low,
                           input logic [7:0] limit, input logic [7:0] dly);
    drain_results();
    repeat (2) @(negedge clk_i);
    write_reg(CFG_SENSOR_KIND, {15'd0, kind});
    write_reg(CFG_RESET_LOW, low);
    write_reg(CFG_EDGE_TIMEOUT, {8'd0, limit});
    write_reg(CFG_SAMPLE_DELAY, {8'd0, dly});
  endtask

  // plays the sensor for one read; a fault forces one wait past the timeout
  task automatic run_read(input logic [39:0] bits, input line_fault_e fault);
    int to, dly, w, k, i, bad_bit;
    to      = sb.edge_limit;
    dly     = sb.delay_ticks();
    // bit faults land early in the frame
    bad_bit = $urandom_range(34, 39);
    send_sample(1'b1, $urandom_range(0, 1) == 1);
    while (sb.phase == RX_REQ_LOW)
      send_sample($urandom_range(0, 1) == 1, $urandom_range(0, 1) == 1);
    hold_line(1'b1, (fault == RESP_STUCK_HIGH) ? to + 1 : pick_wait(to));
    hold_line(1'b0, 1);
    hold_line(1'b0, (fault == RESP_STUCK_LOW) ? to + 1 : pick_wait(to));
    hold_line(1'b1, 1);
    for (i = 39; i >= 0 && sb.busy(); i--) begin
      hold_line(1'b1, (fault == BIT_STUCK_HIGH && i == bad_bit) ? to + 1 : pick_wait(to));
      hold_line(1'b0, 1);
      hold_line(1'b0, (fault == BIT_STUCK_LOW && i == bad_bit) ? to + 1 : pick_wait(to));
      hold_line(1'b1, 1);
      for (k = 1; k < dly; k++) hold_line($urandom_range(0, 1) == 1, 1);
      hold_line(bits[i], 1);
    end
    // stop pulse: high and low share one count in the first round
    w = (fault == STOP_MISSING) ? to + 1 : pick_wait(to);
    hold_line(1'b1, w);
    hold_line(1'b0, 1);
    hold_line(1'b0, (fault == RELEASE_STUCK) ? to + 1 - w : pick_wait(to - w));
    hold_line(1'b1, 1);
    if (fault == EXTRA_EDGE) begin
      w = pick_wait(to);
      hold_line(1'b1, w);
      hold_line(1'b0, 1);
      hold_line(1'b0, pick_wait(to - w));
      hold_line(1'b1, 1);
    end
    hold_line(1'b1, to + 1);
    while (sb.busy()) send_sample(1'b0, $urandom_range(0, 1) == 1);
  endtask

  initial begin
    int k;

    sb               = new();
    rst_ni           = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = CFG_SENSOR_KIND;
    cfg_data         = '0;
    in_if.valid      = 1'b0;
    in_if.start_req  = 1'b0;
    in_if.line_level = 1'b0;
    out_if.ready     = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // power-up sensor kind (DHT2x) with short line timing, negative reading
    idle_noise(3);
    drain_results();
    write_reg(CFG_RESET_LOW, 16'd2);
    write_reg(CFG_EDGE_TIMEOUT, 16'd0);
    write_reg(CFG_SAMPLE_DELAY, 16'd1);
    run_read(make_frame(8'h02, 8'h8C, 8'h80, 8'h65), NO_FAULT);

    // zero registers behave as their minimum; DHT1x
    configure(1'b0, 16'd0, 8'd0, 8'd0);
    // long receiver hold-off while samples keep coming
    tx_steady    = 1'b1;
    pressure_req = 1'b1;
    run_read(make_frame(8'd55, 8'd0, 8'h85, 8'd0), NO_FAULT);
    tx_steady = 1'b0;
    run_read(make_frame(8'h10, 8'h20, 8'h30, 8'h40) ^ 40'h1, NO_FAULT);
    rx_steady = 1'b1;
    run_read(make_frame(8'd40, 8'd1, 8'h12, 8'd9), EXTRA_EDGE);
    rx_steady = 1'b0;
    run_read(make_frame($urandom, $urandom, $urandom, $urandom), STOP_MISSING);
    run_read(make_frame($urandom, $urandom, $urandom, $urandom), RELEASE_STUCK);

    // nonzero timeouts, edge faults
    configure(1'b1, 16'd3, 8'd2, 8'd2);
    for (k = 1; k <= 4; k++)
      run_read(make_frame($urandom, $urandom, $urandom, $urandom), line_fault_e'(k));
    idle_noise(4);

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    drain_results();
    repeat (4) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: dht_sensor_receiver.f
hdl/dhtr_pkg.sv
hdl/dhtr_stream_if.sv
hdl/dhtr_decode.sv
hdl/dht_sensor_receiver.sv
tb/dhtr_read_check_pkg.sv
tb/dht_sensor_receiver_test.sv
